// ----- rtl/core/bdc_pkg.sv -----
// Package for the big-digit cell generator: codes, types, font ROM and helpers.
package bdc_pkg;

    // Depth of the request queue
    localparam int unsigned REQ_DEPTH = 4;

    // Character codes
    localparam logic [7:0] CODE_BLANK  = 8'd254;
    localparam logic [7:0] CODE_FULL   = 8'd255;
    localparam logic [7:0] CODE_DEGREE = 8'd7;
    localparam logic [7:0] CODE_CORNER = 8'd4;

    // Custom glyph segments
    localparam logic [7:0] G_UH = 8'd0;
    localparam logic [7:0] G_LR = 8'd1;
    localparam logic [7:0] G_LL = 8'd3;
    localparam logic [7:0] G_UR = 8'd4;
    localparam logic [7:0] G_LH = 8'd5;
    localparam logic [7:0] G_UL = 8'd6;
    localparam logic [7:0] G_FB = CODE_FULL;
    localparam logic [7:0] G_BL = CODE_BLANK;

    // Request commands
    localparam logic CMD_DIGIT   = 1'b0;
    localparam logic CMD_AZIMUTH = 1'b1;

    // Mark codes
    localparam logic [1:0] MARK_NONE   = 2'd0;
    localparam logic [1:0] MARK_DEGREE = 2'd1;
    localparam logic [1:0] MARK_CORNER = 2'd2;

    // Digit field codes
    localparam logic [4:0] DIGIT_BLANK = 5'h1F;
    localparam logic [3:0] DIGIT_MAX   = 4'd9;

    // Cell geometry
    localparam logic [4:0] BODY_WRITES = 5'd20;
    localparam logic [2:0] LAST_COL    = 3'd4;
    localparam logic [5:0] COL_TENS    = 6'd5;
    localparam logic [5:0] COL_ONES    = 6'd10;

    typedef enum logic [1:0] {
        K_NONE  = 2'd0,
        K_DIGIT = 2'd1,
        K_BLANK = 2'd2
    } t_kind;

    typedef struct packed {
        t_kind       kind;
        logic [3:0]  digit;
        logic [5:0]  col;
        logic [1:0]  mark;
    } t_cell;

    typedef struct packed {
        logic        cmd;
        logic [4:0]  digit;
        logic [5:0]  left_column;
        logic [1:0]  top_row;
        logic [1:0]  mark;
        logic [9:0]  azimuth;
    } t_req;

    // Font ROM: ten digits, four rows of four codes, row-major
    localparam logic [7:0] FONT [10][16] = '{
        '{G_LR, G_UH, G_UH, G_LL, G_FB, G_BL, G_BL, G_FB,
          G_FB, G_BL, G_BL, G_FB, G_UR, G_LH, G_LH, G_UL},
        '{G_BL, G_LR, G_FB, G_BL, G_BL, G_BL, G_FB, G_BL,
          G_BL, G_BL, G_FB, G_BL, G_BL, G_LH, G_FB, G_LH},
        '{G_LR, G_UH, G_UH, G_LL, G_BL, G_BL, G_LH, G_UL,
          G_LR, G_UH, G_BL, G_BL, G_FB, G_LH, G_LH, G_LH},
        '{G_LR, G_UH, G_UH, G_LL, G_BL, G_BL, G_LH, G_UL,
          G_BL, G_BL, G_UH, G_LL, G_UR, G_LH, G_LH, G_UL},
        '{G_FB, G_BL, G_BL, G_FB, G_FB, G_BL, G_BL, G_FB,
          G_UR, G_UH, G_UH, G_FB, G_BL, G_BL, G_BL, G_FB},
        '{G_FB, G_UH, G_UH, G_UH, G_UR, G_LH, G_LH, G_LL,
          G_BL, G_BL, G_BL, G_FB, G_UR, G_LH, G_LH, G_UL},
        '{G_LR, G_UH, G_UH, G_LL, G_FB, G_BL, G_BL, G_BL,
          G_FB, G_UH, G_UH, G_LL, G_UR, G_LH, G_LH, G_UL},
        '{G_UR, G_UH, G_UH, G_FB, G_BL, G_BL, G_LR, G_UL,
          G_BL, G_BL, G_FB, G_BL, G_BL, G_BL, G_FB, G_BL},
        '{G_LR, G_UH, G_UH, G_LL, G_UR, G_LH, G_LH, G_UL,
          G_LR, G_UH, G_UH, G_LL, G_UR, G_LH, G_LH, G_UL},
        '{G_LR, G_UH, G_UH, G_LL, G_UR, G_LH, G_LH, G_FB,
          G_BL, G_BL, G_BL, G_FB, G_UR, G_LH, G_LH, G_UL}
    };

    // Font lookup; digits beyond nine read as blank
    function automatic logic [7:0] font_code(logic [3:0] d, logic [1:0] r, logic [1:0] c);
        logic [7:0] code;
        if (d > DIGIT_MAX) begin
            code = CODE_BLANK;
        end else begin
            code = FONT[d][{r, c}];
        end
        return code;
    endfunction

    // What a signed digit field draws
    function automatic t_kind digit_kind(logic [4:0] d);
        t_kind k;
        if (d == DIGIT_BLANK) begin
            k = K_BLANK;
        end else if (!d[4] && (d[3:0] <= DIGIT_MAX)) begin
            k = K_DIGIT;
        end else begin
            k = K_NONE;
        end
        return k;
    endfunction

    // Number of writes a cell produces
    function automatic logic [4:0] cell_len(t_cell c);
        logic [4:0] n;
        case (c.kind)
            K_DIGIT: begin
                if (c.mark == MARK_DEGREE) begin
                    n = BODY_WRITES + 5'd1;
                end else if (c.mark == MARK_CORNER) begin
                    n = BODY_WRITES + 5'd2;
                end else begin
                    n = BODY_WRITES;
                end
            end
            K_BLANK: n = BODY_WRITES;
            default: n = 5'd0;
        endcase
        return n;
    endfunction

endpackage

// ----- rtl/core/big_digit_cell_generator_top.sv -----
// Top level of the big-digit cell generator: request queue, digit split and write sequencer.
//
//  channel   | handshake          | fields
//  ----------+--------------------+---------------------------------------------------
//  request   | start / busy       | i_cmd i_digit i_left_column i_top_row i_mark i_azimuth
//  cell write| o_valid (strobe)   | o_cell_column o_cell_row o_char_code o_last
//
//  One cell write leaves per cycle while a cell is drawn: 20 to 22 writes for a
//  digit cell and 61 for an azimuth up to 999; above it the hundreds cell is empty
//  and gives no write, as does a request that draws nothing. Between requests the
//  sequencer passes through a fetch state, fed by the registered read of the request
//  queue, and a split state, which hold the two reciprocal multiplications. Requests
//  are queued (REQ_DEPTH deep) while earlier ones are drawn; busy is high only when
//  the queue is full. Reset is synchronous and clears the queue and sequencer. The
//  receiver cannot stall: each write is shown for exactly one cycle.
module big_digit_cell_generator_top #(
    parameter int unsigned DEPTH = bdc_pkg::REQ_DEPTH
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    input  logic              i_cmd,
    input  logic signed [4:0] i_digit,
    input  logic [5:0]        i_left_column,
    input  logic [1:0]        i_top_row,
    input  logic [1:0]        i_mark,
    input  logic [9:0]        i_azimuth,
    output logic              busy,
    output logic              o_valid,
    output logic [5:0]        o_cell_column,
    output logic [2:0]        o_cell_row,
    output logic [7:0]        o_char_code,
    output logic              o_last
);

    import bdc_pkg::*;

    localparam int unsigned AW = $clog2(DEPTH);
    localparam int unsigned CW = $clog2(DEPTH + 1);
    localparam int unsigned RW = $bits(t_req);

    // Reciprocal constants for the decimal split
    localparam logic [15:0] RECIP_HUND = 16'd41;   // 2^12 / 100, rounded up
    localparam logic [14:0] RECIP_TEN  = 15'd205;  // 2^11 / 10, rounded up

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_FETCH = 4'b0010,
        ST_SPLIT = 4'b0100,
        ST_RUN   = 4'b1000
    } t_state;

    t_state          r_state, n_state;
    logic [AW-1:0]   r_wr_ptr, n_wr_ptr;
    logic [AW-1:0]   r_rd_ptr, n_rd_ptr;
    logic [CW-1:0]   r_count, n_count;

    t_req            r_req, n_req;
    logic [3:0]      r_hund, n_hund;
    logic [6:0]      r_rest, n_rest;
    t_cell           r_cell [3];
    t_cell           n_cell [3];
    logic [1:0]      r_row, n_row;
    logic [4:0]      r_step, n_step;
    logic [1:0]      r_r, n_r;
    logic [2:0]      r_c, n_c;

    logic            r_out_valid, n_out_valid;
    logic [5:0]      r_out_col, n_out_col;
    logic [2:0]      r_out_row, n_out_row;
    logic [7:0]      r_out_code, n_out_code;
    logic            r_out_last, n_out_last;

    logic            w_accept;
    logic            w_rd_en;
    t_req            w_wr_req;
    logic [RW-1:0]   w_rd_data;
    t_req            w_rd_req;

    logic [15:0]     w_hund_prod;
    logic [9:0]      w_rest_full;
    logic [14:0]     w_tens_prod;
    logic [3:0]      w_tens;
    logic [6:0]      w_ones_full;

    t_cell           w_cur;
    logic [4:0]      w_cur_len;
    logic            w_emit;
    logic            w_later;
    logic            w_at_end;
    logic            w_run;
    logic            w_job_done;
    logic            w_cell_next;

    // Request queue handshake
    assign w_accept = start && !busy;
    assign busy     = (r_count == CW'(DEPTH));

    assign w_wr_req = '{cmd: i_cmd, digit: i_digit, left_column: i_left_column,
                        top_row: i_top_row, mark: i_mark, azimuth: i_azimuth};

    bdc_ram #(
        .WIDTH (RW),
        .DEPTH (DEPTH)
    ) u_req_ram (
        .i_clk     (i_clk),
        .i_wr_en   (w_accept),
        .i_wr_addr (r_wr_ptr),
        .i_wr_data (w_wr_req),
        .i_rd_en   (w_rd_en),
        .i_rd_addr (r_rd_ptr),
        .o_rd_data (w_rd_data)
    );

    assign w_rd_req = w_rd_data;

    // Hundreds digit from the fetched request
    assign w_hund_prod = {6'd0, w_rd_req.azimuth} * RECIP_HUND;
    assign w_rest_full = w_rd_req.azimuth - 10'({6'd0, w_hund_prod[15:12]} * 10'd100);

    // Tens and ones from the registered remainder
    assign w_tens_prod = {8'd0, r_rest} * RECIP_TEN;
    assign w_tens      = w_tens_prod[14:11];
    assign w_ones_full = r_rest - 7'({3'd0, w_tens} * 7'd10);

    // Sequencer status for the cell at the head
    assign w_cur       = r_cell[0];
    assign w_cur_len   = cell_len(w_cur);
    assign w_emit      = (w_cur.kind != K_NONE);
    assign w_later     = (r_cell[1].kind != K_NONE) || (r_cell[2].kind != K_NONE);
    assign w_at_end    = (r_step == (w_cur_len - 5'd1));
    assign w_run       = (r_state == ST_RUN);
    assign w_job_done  = w_run && (!w_emit || w_at_end) && !w_later;
    assign w_cell_next = w_run && (!w_emit || w_at_end) && w_later;
    assign w_rd_en     = ((r_state == ST_IDLE) || w_job_done) && (r_count != '0);

    // Queue pointers and fill count
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (w_accept) begin
            n_wr_ptr = (r_wr_ptr == AW'(DEPTH - 1)) ? '0 : r_wr_ptr + AW'(1);
        end
        if (w_rd_en) begin
            n_rd_ptr = (r_rd_ptr == AW'(DEPTH - 1)) ? '0 : r_rd_ptr + AW'(1);
        end
        case ({w_accept, w_rd_en})
            2'b10:   n_count = r_count + CW'(1);
            2'b01:   n_count = r_count - CW'(1);
            default: n_count = r_count;
        endcase
    end

    // Control state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:  if (w_rd_en) n_state = ST_FETCH;
            ST_FETCH: n_state = ST_SPLIT;
            ST_SPLIT: n_state = ST_RUN;
            ST_RUN: begin
                if (w_job_done) begin
                    n_state = w_rd_en ? ST_FETCH : ST_IDLE;
                end
            end
            default:  n_state = ST_IDLE;
        endcase
    end

    // Request capture, cell set-up and write counters
    always_comb begin
        n_req   = r_req;
        n_hund  = r_hund;
        n_rest  = r_rest;
        n_cell  = r_cell;
        n_row   = r_row;
        n_step  = r_step;
        n_r     = r_r;
        n_c     = r_c;

        if (r_state == ST_FETCH) begin
            n_req  = w_rd_req;
            n_hund = w_hund_prod[15:12];
            n_rest = w_rest_full[6:0];
        end

        if (r_state == ST_SPLIT) begin
            if (r_req.cmd == CMD_AZIMUTH) begin
                n_row    = 2'd0;
                n_cell[0] = '{kind: (r_hund <= DIGIT_MAX) ? K_DIGIT : K_NONE,
                              digit: r_hund, col: 6'd0, mark: MARK_NONE};
                n_cell[1] = '{kind: K_DIGIT, digit: w_tens, col: COL_TENS, mark: MARK_NONE};
                n_cell[2] = '{kind: K_DIGIT, digit: w_ones_full[3:0], col: COL_ONES,
                              mark: MARK_DEGREE};
            end else begin
                n_row    = r_req.top_row;
                n_cell[0] = '{kind: digit_kind(r_req.digit), digit: r_req.digit[3:0],
                              col: r_req.left_column, mark: r_req.mark};
                n_cell[1] = '{kind: K_NONE, digit: 4'd0, col: 6'd0, mark: MARK_NONE};
                n_cell[2] = '{kind: K_NONE, digit: 4'd0, col: 6'd0, mark: MARK_NONE};
            end
        end

        if (w_cell_next) begin
            n_cell[0]      = r_cell[1];
            n_cell[1]      = r_cell[2];
            n_cell[2].kind = K_NONE;
        end

        // Step counters: body rows of five columns, then the mark writes
        if ((r_state == ST_SPLIT) || w_cell_next) begin
            n_step = 5'd0;
            n_r    = 2'd0;
            n_c    = 3'd0;
        end else if (w_run && w_emit && !w_at_end) begin
            n_step = r_step + 5'd1;
            if (r_step < BODY_WRITES) begin
                if (r_c == LAST_COL) begin
                    n_c = 3'd0;
                    n_r = r_r + 2'd1;
                end else begin
                    n_c = r_c + 3'd1;
                end
            end
        end
    end

    // Cell write composition
    always_comb begin
        n_out_valid = w_run && w_emit;
        n_out_last  = w_run && w_emit && w_at_end && !w_later;
        if (r_step < BODY_WRITES) begin
            n_out_col = w_cur.col + {3'd0, r_c};
            n_out_row = {1'b0, r_row} + {1'b0, r_r};
            if ((w_cur.kind == K_BLANK) || (r_c == LAST_COL)) begin
                n_out_code = CODE_BLANK;
            end else begin
                n_out_code = font_code(w_cur.digit, r_r, r_c[1:0]);
            end
        end else if (r_step == BODY_WRITES) begin
            n_out_row = {1'b0, r_row};
            if (w_cur.mark == MARK_DEGREE) begin
                n_out_col  = w_cur.col + 6'd4;
                n_out_code = CODE_DEGREE;
            end else begin
                n_out_col  = w_cur.col + 6'd3;
                n_out_code = CODE_CORNER;
            end
        end else begin
            n_out_col  = w_cur.col + 6'd3;
            n_out_row  = {1'b0, r_row} + 3'd1;
            n_out_code = CODE_CORNER;
        end
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_wr_ptr    <= '0;
            r_rd_ptr    <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_wr_ptr    <= n_wr_ptr;
            r_rd_ptr    <= n_rd_ptr;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_req      <= n_req;
        r_hund     <= n_hund;
        r_rest     <= n_rest;
        r_cell     <= n_cell;
        r_row      <= n_row;
        r_step     <= n_step;
        r_r        <= n_r;
        r_c        <= n_c;
        r_out_col  <= n_out_col;
        r_out_row  <= n_out_row;
        r_out_code <= n_out_code;
        r_out_last <= n_out_last;
    end

    assign o_valid       = r_out_valid;
    assign o_cell_column = r_out_col;
    assign o_cell_row    = r_out_row;
    assign o_char_code   = r_out_code;
    assign o_last        = r_out_last;

endmodule

// ----- rtl/core/bdc_ram.sv -----
// Generic single-port-write, registered-read RAM.
module bdc_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 4
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule
